// ===== design/piezo_drum_trigger_core_defines.svh =====
// assertion macros for the piezo drum trigger core
`ifndef PIEZO_DRUM_TRIGGER_CORE_DEFINES_SVH
`define PIEZO_DRUM_TRIGGER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PDT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pdt assertion failed");
`define PDT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pdt forbidden condition seen");
`else
`define PDT_ASSERT(lbl, clk, rst_n, prop)
`define PDT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/pdt_pkg.sv =====
// shared types, constants and field selects for the piezo drum trigger
package pdt_pkg;
    localparam int SMP_W      = 10;
    localparam int THR_W      = 10;
    localparam int SENS_W     = 10;
    localparam int DEB_W      = 16;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int PAD_W      = 3;
    localparam int TIME_W     = 32;
    localparam int NUM_W      = 17;
    localparam int BYTE_W     = 8;
    localparam int THRS_W     = 60;
    localparam int NOTES_W    = 42;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 60;
    localparam int QDEPTH     = 4;
    localparam int QAW        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SENS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTES = 2'd3;

    localparam logic [SENS_W-1:0]  SENS_RST  = 10'd120;
    localparam logic [DEB_W-1:0]   DEB_RST   = 16'd20;
    localparam logic [THRS_W-1:0]  THRS_RST  = 60'd22540009865256985;
    localparam logic [NOTES_W-1:0] NOTES_RST = 42'd2562903352520;

    localparam logic              ACT_TICK      = 1'b1;
    localparam logic [VEL_W-1:0]  VEL_MAX       = 7'd127;
    localparam logic [BYTE_W-1:0] BYTE_NOTE_ON  = 8'h90;
    localparam logic [BYTE_W-1:0] BYTE_NOTE_OFF = 8'h80;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_msg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [THR_W-1:0] thr_sel(input logic [THRS_W-1:0] all,
                                                 input logic [PAD_W-1:0] idx);
        case (idx)
            3'd0: thr_sel = all[9:0];
            3'd1: thr_sel = all[19:10];
            3'd2: thr_sel = all[29:20];
            3'd3: thr_sel = all[39:30];
            3'd4: thr_sel = all[49:40];
            3'd5: thr_sel = all[59:50];
            default: thr_sel = '0;
        endcase
    endfunction

    function automatic logic [NOTE_W-1:0] note_sel(input logic [NOTES_W-1:0] all,
                                                   input logic [PAD_W-1:0] idx);
        case (idx)
            3'd0: note_sel = all[6:0];
            3'd1: note_sel = all[13:7];
            3'd2: note_sel = all[20:14];
            3'd3: note_sel = all[27:21];
            3'd4: note_sel = all[34:28];
            3'd5: note_sel = all[41:35];
            default: note_sel = '0;
        endcase
    endfunction
endpackage

// ===== design/pdt_if.sv =====
// valid/ready channel interfaces for pad items and message bytes
interface pdt_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [2:0] pad;
    logic [9:0] sample;

    modport source (output valid, output action, output pad, output sample, input ready);
    modport sink (input valid, input action, input pad, input sample, output ready);
endinterface

interface pdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== design/pdt_front.sv =====
// front end: time base, pad state, serial velocity divider and message launch
module pdt_front #(
    parameter int NUM_PADS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pdt_in_if.sink                            i_item,
    input  logic                              i_cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pdt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_push,
    output pdt_pkg::t_msg                     o_msg,
    input  pdt_pkg::t_qstat                   i_qstat
);
    import pdt_pkg::*;

    localparam int PAW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
    localparam logic [PAD_W-1:0] PAD_LIMIT = PAD_W'(NUM_PADS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_SAT  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [SENS_W-1:0]  r_sens;
    logic [DEB_W-1:0]   r_deb;
    logic [THRS_W-1:0]  r_thrs;
    logic [NOTES_W-1:0] r_notes;

    logic [TIME_W-1:0]  r_now;
    logic               r_play [NUM_PADS];
    logic [VEL_W-1:0]   r_peak [NUM_PADS];
    logic [TIME_W-1:0]  r_rel  [NUM_PADS];

    logic [1:0]         r_state;
    logic [PAW-1:0]     r_pad;
    logic [SMP_W-1:0]   r_smp;
    logic [NUM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_dsh;
    logic [VEL_W-1:0]   r_quo;
    logic [2:0]         r_cnt;

    logic               c_take;
    logic [PAD_W-1:0]   c_pad3;
    logic [THR_W-1:0]   c_thr;
    logic [TIME_W-1:0]  c_elapsed;
    logic               c_armed;
    logic               c_ge;
    logic               c_start;
    logic [NUM_W-1:0]   c_num;
    logic [SENS_W-1:0]  c_d;
    logic               c_trial;
    logic [VEL_W-1:0]   c_q;

    assign i_item.ready = (r_state == S_IDLE);
    assign c_take       = i_item.valid && (r_state == S_IDLE);

    always_comb begin
        c_pad3    = PAD_W'(r_pad);
        c_thr     = thr_sel(r_thrs, c_pad3);
        c_elapsed = r_now - r_rel[r_pad];
        c_armed   = c_elapsed >= {{(TIME_W-DEB_W){1'b0}}, r_deb};
        c_ge      = r_smp >= c_thr;
        c_start   = r_play[r_pad] || c_armed;
        c_num     = {{(NUM_W-SMP_W){1'b0}}, r_smp} * NUM_W'(VEL_MAX);
        c_d       = r_sens - c_thr;
        c_trial   = r_rem >= r_dsh;
        c_q       = {r_quo[VEL_W-2:0], c_trial};
    end

    assign o_push   = (r_state == S_EVAL) && !c_ge && r_play[r_pad] && !i_qstat.full;
    assign o_msg.note = note_sel(r_notes, c_pad3);
    assign o_msg.vel  = r_peak[r_pad];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens  <= SENS_RST;
            r_deb   <= DEB_RST;
            r_thrs  <= THRS_RST;
            r_notes <= NOTES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENS:  r_sens  <= i_cfg_data[SENS_W-1:0];
                CFG_DEB:   r_deb   <= i_cfg_data[DEB_W-1:0];
                CFG_THRS:  r_thrs  <= i_cfg_data[THRS_W-1:0];
                CFG_NOTES: r_notes <= i_cfg_data[NOTES_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers of the divider
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_EVAL: begin
                r_rem <= c_num;
                r_dsh <= {{(NUM_W-SENS_W-6){1'b0}}, c_d, 6'd0};
                r_quo <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                if (c_trial) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_quo <= c_q;
                r_cnt <= r_cnt + 3'd1;
            end
            default: ;
        endcase
        if (c_take) begin
            r_pad <= i_item.pad[PAW-1:0];
            r_smp <= i_item.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_now   <= '0;
            for (int i = 0; i < NUM_PADS; i++) begin
                r_play[i] <= 1'b0;
                r_peak[i] <= '0;
                r_rel[i]  <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (c_take) begin
                        if (i_item.action == ACT_TICK) begin
                            r_now <= r_now + 32'd1;
                        end else if (i_item.pad < PAD_LIMIT) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    if (c_ge) begin
                        r_state <= S_IDLE;
                        if (c_start) begin
                            r_play[r_pad] <= 1'b1;
                            if (r_sens == c_thr) begin
                                if (r_smp != '0) begin
                                    r_peak[r_pad] <= VEL_MAX;
                                end
                            end else if (r_sens > c_thr) begin
                                r_state <= S_SAT;
                            end
                        end
                    end else if (!r_play[r_pad]) begin
                        r_state <= S_IDLE;
                    end else if (!i_qstat.full) begin
                        r_play[r_pad] <= 1'b0;
                        r_peak[r_pad] <= '0;
                        r_rel[r_pad]  <= r_now;
                        r_state       <= S_IDLE;
                    end
                end
                S_SAT: begin
                    // quotient of 128 or more clips to full velocity
                    if (r_rem >= {r_dsh[NUM_W-2:0], 1'b0}) begin
                        r_peak[r_pad] <= VEL_MAX;
                        r_state       <= S_IDLE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 3'd6) begin
                        if (c_q > r_peak[r_pad]) begin
                            r_peak[r_pad] <= c_q;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/pdt_fifo.sv =====
// short message queue between the front end and the byte sender
module pdt_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pdt_pkg::t_msg   i_msg,
    input  logic            i_pop,
    output pdt_pkg::t_msg   o_head,
    output pdt_pkg::t_qstat o_stat
);
    import pdt_pkg::*;

    t_msg           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           c_wr;
    logic           c_rd;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign c_wr   = i_push && !o_stat.full;
    assign c_rd   = i_pop && !o_stat.empty;
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (c_wr) begin
            r_mem[r_wp] <= i_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_wr) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (c_rd) begin
                r_rp <= r_rp + QAW'(1);
            end
            case ({c_wr, c_rd})
                2'b10:   r_cnt <= r_cnt + (QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW+1)'(1);
                default: ;
            endcase
        end
    end
endmodule

// ===== design/pdt_back.sv =====
// back end: sends the six bytes of each queued note-on/note-off message
module pdt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pdt_pkg::t_msg   i_head,
    input  pdt_pkg::t_qstat i_qstat,
    output logic            o_pop,
    pdt_out_if.source       o_res
);
    import pdt_pkg::*;

    localparam logic [2:0] B_ON    = 3'd0;
    localparam logic [2:0] B_NOTE1 = 3'd1;
    localparam logic [2:0] B_VEL1  = 3'd2;
    localparam logic [2:0] B_OFF   = 3'd3;
    localparam logic [2:0] B_NOTE2 = 3'd4;
    localparam logic [2:0] B_VEL2  = 3'd5;

    logic       r_busy;
    logic [2:0] r_step;
    t_msg       r_rec;
    logic       c_xfer;
    logic       c_last;

    assign c_last      = (r_step == B_VEL2);
    assign c_xfer      = r_busy && o_res.ready;
    assign o_pop       = !i_qstat.empty && (!r_busy || (c_xfer && c_last));
    assign o_res.valid = r_busy;
    assign o_res.last  = c_last;

    always_comb begin
        case (r_step)
            B_ON:    o_res.out_byte = BYTE_NOTE_ON;
            B_NOTE1: o_res.out_byte = {1'b0, r_rec.note};
            B_VEL1:  o_res.out_byte = {1'b0, r_rec.vel};
            B_OFF:   o_res.out_byte = BYTE_NOTE_OFF;
            B_NOTE2: o_res.out_byte = {1'b0, r_rec.note};
            B_VEL2:  o_res.out_byte = {1'b0, r_rec.vel};
            default: o_res.out_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= B_ON;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_step <= B_ON;
        end else if (c_xfer) begin
            if (c_last) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end
endmodule

// ===== design/piezo_drum_trigger_core.sv =====
// piezo drum trigger core: six-pad peak velocity trigger with note message output
// a tick advances the time base; a pad sample is evaluated and, when the velocity
// divider runs, passes one saturation check plus 7 quotient steps of a shared divider
// a release queues a message; each message leaves as 6 byte transfers, one per cycle while the receiver is ready
// synchronous active-low reset clears time, pad states, queue and loads default settings
`include "piezo_drum_trigger_core_defines.svh"
module piezo_drum_trigger_core #(
    parameter int NUM_PADS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pdt_in_if.sink                            i_item,
    pdt_out_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pdt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pdt_pkg::*;

    logic   q_push;
    logic   q_pop;
    t_msg   q_in;
    t_msg   q_head;
    t_qstat q_stat;

    pdt_front #(
        .NUM_PADS (NUM_PADS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (q_push),
        .o_msg      (q_in),
        .i_qstat    (q_stat)
    );

    pdt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_msg   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    pdt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_qstat (q_stat),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

    `PDT_NEVER(a_push_when_full, i_clk, i_rst_n, q_push && q_stat.full)
    `PDT_NEVER(a_pop_when_empty, i_clk, i_rst_n, q_pop && q_stat.empty)
    `PDT_ASSERT(a_sample_blocks, i_clk, i_rst_n, (i_item.valid && i_item.ready && (i_item.action != ACT_TICK) && (i_item.pad < PAD_W'(NUM_PADS))) |=> !i_item.ready)
    `PDT_ASSERT(a_run_starts_on, i_clk, i_rst_n, (o_res.valid && o_res.ready && o_res.last) |=> (!o_res.valid || (o_res.out_byte == BYTE_NOTE_ON)))
endmodule
